// File: rtl/voxel_column_gap_close_and_fill_core_assert.svh
// Assertion macros for the voxel column gap close and fill core
`ifndef VOXEL_COLUMN_GAP_CLOSE_AND_FILL_CORE_ASSERT_SVH
`define VOXEL_COLUMN_GAP_CLOSE_AND_FILL_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define VCGF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define VCGF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/vcgf_pkg.sv
// Shared constants, types and functions of the voxel column gap close and fill core
package vcgf_pkg;

	localparam int COLUMN_HEIGHT_DEF = 64;
	localparam int CNT_W = 6;
	localparam logic [CNT_W-1:0] GAP_LIMIT_RST = 6'd5;

	// Scan state handed from cell to cell alongside the masks
	typedef struct packed {
		logic             valid;
		logic             seen;    // an occupied voxel lies below
		logic             multi;   // a second occupied run has started
		logic [CNT_W-1:0] gap;     // empty voxels since the last occupied one
		logic [CNT_W-1:0] closed;  // voxels set by gap closing so far
	} cell_ctrl_t;

	function automatic logic [3:0] popcount8(input logic [7:0] v);
		logic [3:0] n;
		n = '0;
		for (int k = 0; k < 8; k++) begin
			n = n + {3'b000, v[k]};
		end
		return n;
	endfunction

endpackage

// File: rtl/vcgf_cell.sv
// One scan cell: examines one voxel of the column and closes the gap it ends
module vcgf_cell import vcgf_pkg::*; #(
	parameter int COLUMN_HEIGHT = COLUMN_HEIGHT_DEF,
	parameter int IDX = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [CNT_W-1:0]         gap_limit,
	input  cell_ctrl_t               ctrl,
	input  logic [COLUMN_HEIGHT-1:0] occ,
	input  logic [COLUMN_HEIGHT-1:0] gnd,
	input  logic [COLUMN_HEIGHT-1:0] filled,
	input  logic [COLUMN_HEIGHT-1:0] pend,
	output cell_ctrl_t               ctrl_s1,
	output logic [COLUMN_HEIGHT-1:0] occ_s1,
	output logic [COLUMN_HEIGHT-1:0] gnd_s1,
	output logic [COLUMN_HEIGHT-1:0] filled_s1,
	output logic [COLUMN_HEIGHT-1:0] pend_s1
);

	cell_ctrl_t               ctrl_d;
	logic [COLUMN_HEIGHT-1:0] filled_d;
	logic [COLUMN_HEIGHT-1:0] pend_d;

	always_comb begin
		ctrl_d   = ctrl;
		filled_d = filled;
		pend_d   = pend;
		if (occ[IDX]) begin
			// an occupied voxel above a gap starts a new run; close the gap if short enough
			if (ctrl.seen && (ctrl.gap != '0)) begin
				ctrl_d.multi = 1'b1;
				if (ctrl.gap <= gap_limit) begin
					filled_d      = filled | pend;
					ctrl_d.closed = ctrl.closed + ctrl.gap;
				end
			end
			ctrl_d.seen = 1'b1;
			ctrl_d.gap  = '0;
			pend_d      = '0;
		end else if (ctrl.seen) begin
			pend_d[IDX] = 1'b1;
			ctrl_d.gap  = ctrl.gap + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1 <= ctrl_d;
		end
	end

	always_ff @(posedge clk) begin
		occ_s1    <= occ;
		gnd_s1    <= gnd;
		filled_s1 <= filled_d;
		pend_s1   <= pend_d;
	end

endmodule

// File: rtl/vcgf_bedrock.sv
// Bedrock fill below the lowest ground voxel, with a two-stage count of the voxels set
module vcgf_bedrock import vcgf_pkg::*; #(
	parameter int COLUMN_HEIGHT = COLUMN_HEIGHT_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_ctrl_t               ctrl,
	input  logic [COLUMN_HEIGHT-1:0] gnd,
	input  logic [COLUMN_HEIGHT-1:0] filled,
	output logic                     done,
	output logic [COLUMN_HEIGHT-1:0] filled_mask,
	output logic                     empty_column,
	output logic                     multi_run,
	output logic [CNT_W-1:0]         closed_count,
	output logic [CNT_W-1:0]         bedrock_count
);

	localparam int NGRP = (COLUMN_HEIGHT + 7) / 8;
	localparam int PADW = NGRP * 8;

	logic [COLUMN_HEIGHT-1:0] below;
	logic [COLUMN_HEIGHT-1:0] fresh;
	logic [PADW-1:0]          fresh_pad;

	logic                     valid_s1;
	logic                     seen_s1;
	logic                     multi_s1;
	logic [CNT_W-1:0]         closed_s1;
	logic [COLUMN_HEIGHT-1:0] filled_s1;
	logic [3:0]               grp_s1 [NGRP];

	logic [CNT_W:0]           sum;

	// every bit below the lowest set ground bit
	assign below     = (gnd == '0) ? '0 : ((gnd - COLUMN_HEIGHT'(1)) & ~gnd);
	assign fresh     = below & ~filled;
	assign fresh_pad = PADW'(fresh);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= ctrl.valid;
			done     <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		seen_s1   <= ctrl.seen;
		multi_s1  <= ctrl.multi;
		closed_s1 <= ctrl.closed;
		filled_s1 <= filled | below;
		for (int g = 0; g < NGRP; g++) begin
			grp_s1[g] <= popcount8(fresh_pad[g*8 +: 8]);
		end
	end

	always_comb begin
		sum = '0;
		for (int g = 0; g < NGRP; g++) begin
			sum = sum + (CNT_W+1)'(grp_s1[g]);
		end
	end

	always_ff @(posedge clk) begin
		filled_mask   <= filled_s1;
		empty_column  <= !seen_s1;
		multi_run     <= multi_s1;
		closed_count  <= closed_s1;
		bedrock_count <= sum[CNT_W-1:0];
	end

endmodule

// File: rtl/voxel_column_gap_close_and_fill_core.sv
// Top level: chain of scan cells, one per voxel, followed by the bedrock fill stages
// Throughput: one column per cycle; each voxel has its own cell, and busy stays low.
// A result sits on the outputs for one cycle with done high; the receiver cannot stall.
// Reset clears all valid flags and loads gap_limit with 5; payload registers are not reset.
`include "voxel_column_gap_close_and_fill_core_assert.svh"
module voxel_column_gap_close_and_fill_core import vcgf_pkg::*; #(
	parameter int COLUMN_HEIGHT = COLUMN_HEIGHT_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     gap_limit_we,
	input  logic [CNT_W-1:0]         gap_limit,
	input  logic [COLUMN_HEIGHT-1:0] occupied_mask,
	input  logic [COLUMN_HEIGHT-1:0] ground_mask,
	output logic                     done,
	output logic [COLUMN_HEIGHT-1:0] filled_mask,
	output logic                     empty_column,
	output logic                     multi_run,
	output logic [CNT_W-1:0]         closed_count,
	output logic [CNT_W-1:0]         bedrock_count
);

	logic [CNT_W-1:0]         gap_limit_q;

	cell_ctrl_t               ctrl   [COLUMN_HEIGHT+1];
	logic [COLUMN_HEIGHT-1:0] occ    [COLUMN_HEIGHT+1];
	logic [COLUMN_HEIGHT-1:0] gnd    [COLUMN_HEIGHT+1];
	logic [COLUMN_HEIGHT-1:0] filled [COLUMN_HEIGHT+1];
	logic [COLUMN_HEIGHT-1:0] pend   [COLUMN_HEIGHT+1];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q <= GAP_LIMIT_RST;
		end else if (gap_limit_we) begin
			gap_limit_q <= gap_limit;
		end
	end

	// chain entry: ground counts only where occupied
	always_comb begin
		ctrl[0]       = '0;
		ctrl[0].valid = start && !busy;
		occ[0]        = occupied_mask;
		gnd[0]        = ground_mask & occupied_mask;
		filled[0]     = occupied_mask;
		pend[0]       = '0;
	end

	for (genvar i = 0; i < COLUMN_HEIGHT; i++) begin : g_cell
		vcgf_cell #(
			.COLUMN_HEIGHT(COLUMN_HEIGHT),
			.IDX(i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.gap_limit (gap_limit_q),
			.ctrl      (ctrl[i]),
			.occ       (occ[i]),
			.gnd       (gnd[i]),
			.filled    (filled[i]),
			.pend      (pend[i]),
			.ctrl_s1   (ctrl[i+1]),
			.occ_s1    (occ[i+1]),
			.gnd_s1    (gnd[i+1]),
			.filled_s1 (filled[i+1]),
			.pend_s1   (pend[i+1])
		);
	end

	vcgf_bedrock #(
		.COLUMN_HEIGHT(COLUMN_HEIGHT)
	) u_bedrock (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl[COLUMN_HEIGHT]),
		.gnd           (gnd[COLUMN_HEIGHT]),
		.filled        (filled[COLUMN_HEIGHT]),
		.done          (done),
		.filled_mask   (filled_mask),
		.empty_column  (empty_column),
		.multi_run     (multi_run),
		.closed_count  (closed_count),
		.bedrock_count (bedrock_count)
	);

	`VCGF_ASSERT_IMP(a_empty_is_clean, clk, arst_n, done && empty_column, (filled_mask == '0) && !multi_run && (closed_count == '0) && (bedrock_count == '0), "empty column result not clean")
	`VCGF_ASSERT_IMP(a_closed_needs_runs, clk, arst_n, done && (closed_count != '0), multi_run, "gap closed without two occupied runs")
	`VCGF_ASSERT_IMP(a_bedrock_reaches_bottom, clk, arst_n, done && (bedrock_count != '0), filled_mask[0], "bedrock fill left the bottom voxel empty")

endmodule
